### rtl/sagq_pkg.sv
// Shared constants for the sample average, gamma and quantize block.
`default_nettype none
package sagq_pkg;
  localparam int SUM_W      = 32;
  localparam int CNT_W      = 16;
  localparam int BYTE_W     = 8;
  localparam int DIV_STEPS  = 16;
  localparam int SQRT_STEPS = 8;
  localparam int LANE_LAT   = 1 + DIV_STEPS + SQRT_STEPS + 1;
  localparam logic [0:0] REG_SAMPLE_COUNT = 1'b0;
  localparam logic [0:0] REG_GAMMA_ENABLE = 1'b1;
endpackage
`default_nettype wire

### rtl/sample_average_gamma_quantize.sv
// Top level: config registers, three color lanes, valid pipeline and output merge.
//
// Usage: drive red_sum, green_sum and blue_sum (signed Q15.16 sample sums) and
// raise start; the word is taken at any edge where start is high and busy low.
// busy is high only during reset, so a new word may enter every cycle.
// Each word is divided by sample_count (0 counts as 1), optionally square
// rooted (gamma_enable), clamped and quantized to three bytes plus packed_rgb.
// The result appears with done high after the entry register, the 16-step
// divider pipeline, the 8-step root pipeline and the exit register.
// Throughput: one word per cycle outside reset.
// done lasts one cycle; the receiver cannot stall, results are not held.
// Config: cfg_we writes cfg_data to register cfg_index (0 sample_count,
// 1 gamma_enable); write only while no word is in flight.
// Reset (rst, synchronous) sets sample_count 1, gamma_enable 1 and clears
// all words in flight.
`default_nettype none
module sample_average_gamma_quantize (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               start,
  output logic                                    busy,
  output logic                                    done,
  input  wire logic                               cfg_we,
  input  wire logic [0:0]                         cfg_index,
  input  wire logic [sagq_pkg::CNT_W-1:0]         cfg_data,
  input  wire logic signed [sagq_pkg::SUM_W-1:0]  red_sum,
  input  wire logic signed [sagq_pkg::SUM_W-1:0]  green_sum,
  input  wire logic signed [sagq_pkg::SUM_W-1:0]  blue_sum,
  output logic [sagq_pkg::BYTE_W-1:0]             red_byte,
  output logic [sagq_pkg::BYTE_W-1:0]             green_byte,
  output logic [sagq_pkg::BYTE_W-1:0]             blue_byte,
  output logic [23:0]                             packed_rgb
);
  localparam int LAT = sagq_pkg::LANE_LAT;

  logic [sagq_pkg::CNT_W-1:0] sample_count;
  logic                       gamma_enable;
  logic [sagq_pkg::CNT_W-1:0] n_eff;
  logic [LAT-1:0]             vpipe;
  logic                       accept;

  assign busy   = rst;
  assign accept = start & ~busy;
  assign n_eff  = (sample_count == '0) ? sagq_pkg::CNT_W'(1) : sample_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= sagq_pkg::CNT_W'(1);
      gamma_enable <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        sagq_pkg::REG_SAMPLE_COUNT: sample_count <= cfg_data;
        sagq_pkg::REG_GAMMA_ENABLE: gamma_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst)
      vpipe <= '0;
    else
      vpipe <= {vpipe[LAT-2:0], accept};
  end

  sagq_lane u_red (
    .clk(clk), .sum(red_sum), .n(n_eff), .gam(gamma_enable), .byte_out(red_byte)
  );
  sagq_lane u_green (
    .clk(clk), .sum(green_sum), .n(n_eff), .gam(gamma_enable), .byte_out(green_byte)
  );
  sagq_lane u_blue (
    .clk(clk), .sum(blue_sum), .n(n_eff), .gam(gamma_enable), .byte_out(blue_byte)
  );

  assign done       = vpipe[LAT-1];
  assign packed_rgb = {red_byte, green_byte, blue_byte};

  a_rst_clears: assert property (@(posedge clk) rst |=> !done)
    else $error("done after reset");
  a_n_nonzero: assert property (@(posedge clk) disable iff (rst) n_eff != '0)
    else $error("zero divisor");
  a_pack: assert property (@(posedge clk) disable iff (rst)
    done |-> packed_rgb[23:16] == red_byte && packed_rgb[7:0] == blue_byte)
    else $error("packed word mismatch");
  a_no_accept_busy: assert property (@(posedge clk) busy |=> !vpipe[0])
    else $error("word taken while busy");
endmodule
`default_nettype wire

### rtl/sagq_lane.sv
// One color lane: pipelined divide by sample count, square root and byte quantize.
`default_nettype none
module sagq_lane (
  input  wire logic                                clk,
  input  wire logic signed [sagq_pkg::SUM_W-1:0]   sum,
  input  wire logic        [sagq_pkg::CNT_W-1:0]   n,
  input  wire logic                                gam,
  output logic             [sagq_pkg::BYTE_W-1:0]  byte_out
);
  localparam int DS = sagq_pkg::DIV_STEPS;
  localparam int SS = sagq_pkg::SQRT_STEPS;

  logic [15:0] rem  [0:DS];
  logic [15:0] num  [0:DS];
  logic [15:0] nn   [0:DS];
  logic        zr   [0:DS];
  logic        st   [0:DS];
  logic        gm   [0:DS];

  logic [7:0]  root [0:SS];
  logic [15:0] qv   [0:SS];
  logic        qz   [0:SS];
  logic        qs   [0:SS];
  logic        qg   [0:SS];

  // entry: high part decides saturation, seeds the remainder; low part shifts in
  always_ff @(posedge clk) begin
    zr[0]  <= sum[31] | (sum == '0);
    st[0]  <= {1'b0, sum[30:16]} >= n;
    rem[0] <= {1'b0, sum[30:16]};
    num[0] <= sum[15:0];
    nn[0]  <= n;
    gm[0]  <= gam;
  end

  for (genvar k = 1; k <= DS; k++) begin : g_div
    logic [16:0] r2;
    logic        ge;
    assign r2 = {rem[k-1], num[k-1][15]};
    assign ge = r2 >= {1'b0, nn[k-1]};
    always_ff @(posedge clk) begin
      rem[k] <= ge ? 16'(r2 - {1'b0, nn[k-1]}) : r2[15:0];
      num[k] <= {num[k-1][14:0], ge};
      nn[k]  <= nn[k-1];
      zr[k]  <= zr[k-1];
      st[k]  <= st[k-1];
      gm[k]  <= gm[k-1];
    end
  end

  assign root[0] = '0;
  assign qv[0]   = num[DS];
  assign qz[0]   = zr[DS];
  assign qs[0]   = st[DS];
  assign qg[0]   = gm[DS];

  for (genvar j = 1; j <= SS; j++) begin : g_sqrt
    logic [7:0]  trial;
    logic [15:0] sq;
    assign trial = root[j-1] | (8'h80 >> (j - 1));
    assign sq    = trial * trial;
    always_ff @(posedge clk) begin
      root[j] <= (sq <= qv[j-1]) ? trial : root[j-1];
      qv[j]   <= qv[j-1];
      qz[j]   <= qz[j-1];
      qs[j]   <= qs[j-1];
      qg[j]   <= qg[j-1];
    end
  end

  always_ff @(posedge clk) begin
    if (qz[SS])
      byte_out <= '0;
    else if (qs[SS])
      byte_out <= '1;
    else if (qg[SS])
      byte_out <= root[SS];
    else
      byte_out <= qv[SS][15:8];
  end
endmodule
`default_nettype wire
